FILE: rtl/rgbe_rle_scanline_decoder_macros.svh
// assertion macros shared by the rgbe rle scanline decoder rtl
// no dependencies; the including module provides clk and rst_n
`ifndef RGBE_RLE_SCANLINE_DECODER_MACROS_SVH
`define RGBE_RLE_SCANLINE_DECODER_MACROS_SVH
`ifndef SYNTH
// property checked at every clock edge outside reset
`define RGBERLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// antecedent in this cycle implies consequent in the next
`define RGBERLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RGBERLE_ASSERT(lbl, prop, msg)
`define RGBERLE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/rgberle_pkg.sv
// types and constants of the rgbe rle scanline decoder
// no dependencies
package rgberle_pkg;

  localparam int unsigned DIM_W = 15;

  // configuration register indexes
  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 15'd8;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 15'd1;
  localparam logic [DIM_W-1:0] FLAT_LIMIT   = 15'd8;

  localparam logic [7:0] HDR_MAGIC = 8'd2;

  // result kinds
  localparam logic [1:0] KIND_SPAN  = 2'd0;
  localparam logic [1:0] KIND_PIXEL = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_WIDTH    = 2'd1;
  localparam logic [1:0] ERR_ZERO     = 2'd2;
  localparam logic [1:0] ERR_OVERRUN  = 2'd3;

  localparam logic [1:0] PLANE_LAST = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_COUNT   = 2'd1,
    PH_RUNVAL  = 2'd2,
    PH_LITERAL = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       start_image;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       error_code;
    logic [DIM_W-1:0] row;
    logic [1:0]       channel;
    logic [DIM_W-1:0] column;
    logic [6:0]       span_length;
    logic [7:0]       span_value;
    logic [7:0]       pixel_red;
    logic [7:0]       pixel_green;
    logic [7:0]       pixel_blue;
    logic [7:0]       pixel_exponent;
    logic             image_done;
  } out_item_t;

endpackage

FILE: rtl/rgberle_dec.sv
// decode state and per-byte decode logic of the rgbe rle scanline decoder
// depends on rgberle_pkg and rgbe_rle_scanline_decoder_macros.svh
`include "rgbe_rle_scanline_decoder_macros.svh"

module rgberle_dec (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  rgberle_pkg::in_item_t    item,
  input  logic [14:0]              img_width,
  input  logic [14:0]              img_height,
  output logic                     res_valid,
  output rgberle_pkg::out_item_t   res
);
  import rgberle_pkg::*;

  phase_t            phase_r, phase_nxt, eff_phase;
  logic [23:0]       held_r, held_nxt, eff_held;
  logic [1:0]        pos_r, pos_nxt, eff_pos;
  logic              flat_r, flat_nxt, eff_flat;
  logic [1:0]        plane_r, plane_nxt, eff_plane;
  logic [DIM_W-1:0]  col_r, col_nxt, eff_col;
  logic [DIM_W-1:0]  row_r, row_nxt, eff_row;
  logic [7:0]        lit_r, lit_nxt, eff_lit;
  logic [6:0]        run_r, run_nxt, eff_run;
  logic              halted_r, halted_nxt, eff_halted;

  logic [7:0]        b;
  logic              in_start;
  logic              active;
  logic              use_flat;
  logic [DIM_W-1:0]  room;
  logic [DIM_W:0]    row_inc;
  logic              row_done;
  logic [DIM_W:0]    pix_col_inc;
  logic [DIM_W:0]    span_sum;
  logic              do_pixel;
  logic              do_span;
  logic              do_error;
  logic [1:0]        err_code;
  logic [6:0]        span_len;

  assign b        = item.file_byte;
  assign in_start = item.start_image;

  // start of image clears the state before this byte is used
  assign eff_phase  = in_start ? PH_HEADER : phase_r;
  assign eff_held   = in_start ? '0 : held_r;
  assign eff_pos    = in_start ? '0 : pos_r;
  assign eff_flat   = in_start ? 1'b0 : flat_r;
  assign eff_plane  = in_start ? '0 : plane_r;
  assign eff_col    = in_start ? '0 : col_r;
  assign eff_row    = in_start ? '0 : row_r;
  assign eff_lit    = in_start ? '0 : lit_r;
  assign eff_run    = in_start ? '0 : run_r;
  assign eff_halted = in_start ? 1'b0 : halted_r;

  assign active = !eff_halted && (img_width != '0) && (img_height != '0)
                  && (eff_row < img_height);
  assign use_flat = eff_flat || (img_width < FLAT_LIMIT) || (eff_phase == PH_HEADER);
  assign room = (eff_col < img_width) ? (img_width - eff_col) : '0;
  assign row_inc  = {1'b0, eff_row} + 16'd1;
  assign row_done = row_inc >= {1'b0, img_height};
  assign pix_col_inc = {1'b0, eff_col} + 16'd1;
  assign span_len = (eff_phase == PH_RUNVAL) ? eff_run : 7'd1;
  assign span_sum = {1'b0, eff_col} + {9'd0, span_len};

  always_comb begin
    phase_nxt  = eff_phase;
    held_nxt   = eff_held;
    pos_nxt    = eff_pos;
    flat_nxt   = eff_flat;
    plane_nxt  = eff_plane;
    col_nxt    = eff_col;
    row_nxt    = eff_row;
    lit_nxt    = eff_lit;
    run_nxt    = eff_run;
    halted_nxt = eff_halted;
    do_pixel   = 1'b0;
    do_span    = 1'b0;
    do_error   = 1'b0;
    err_code   = ERR_NONE;
    res_valid  = 1'b0;
    res        = '0;

    if (active) begin
      if (use_flat) begin
        if (eff_pos != 2'd3) begin
          // gather the first three bytes of a pixel or header
          held_nxt = eff_held | (24'(b) << {eff_pos, 3'b000});
          pos_nxt  = eff_pos + 2'd1;
        end else begin
          held_nxt = '0;
          pos_nxt  = '0;
          if (eff_flat || (img_width < FLAT_LIMIT)) begin
            do_pixel = 1'b1;
          end else if ((eff_held[7:0] != HDR_MAGIC) || (eff_held[15:8] != HDR_MAGIC)
                       || eff_held[23]) begin
            // not a scanline header: rest of the image is flat
            flat_nxt = 1'b1;
            do_pixel = 1'b1;
          end else if ({eff_held[22:16], b} != img_width) begin
            do_error = 1'b1;
            err_code = ERR_WIDTH;
          end else begin
            phase_nxt = PH_COUNT;
            plane_nxt = '0;
            col_nxt   = '0;
          end
        end
      end else begin
        case (eff_phase)
          PH_COUNT: begin
            if (b[7] && (b[6:0] != 7'd0)) begin
              run_nxt = b[6:0];
              if ({8'd0, b[6:0]} > room) begin
                do_error = 1'b1;
                err_code = ERR_OVERRUN;
              end else begin
                phase_nxt = PH_RUNVAL;
              end
            end else if (b == 8'd0) begin
              do_error = 1'b1;
              err_code = ERR_ZERO;
            end else if ({7'd0, b} > room) begin
              do_error = 1'b1;
              err_code = ERR_OVERRUN;
            end else begin
              lit_nxt   = b;
              phase_nxt = PH_LITERAL;
            end
          end
          PH_RUNVAL: begin
            do_span = 1'b1;
          end
          PH_LITERAL: begin
            if (eff_lit != 8'd0) begin
              lit_nxt = eff_lit - 8'd1;
            end
            do_span = 1'b1;
          end
          default: begin
            phase_nxt = PH_HEADER;
          end
        endcase
      end
    end

    if (do_pixel) begin
      res_valid          = 1'b1;
      res.kind           = KIND_PIXEL;
      res.row            = eff_row;
      res.column         = eff_col;
      res.pixel_red      = eff_held[7:0];
      res.pixel_green    = eff_held[15:8];
      res.pixel_blue     = eff_held[23:16];
      res.pixel_exponent = b;
      if (pix_col_inc >= {1'b0, img_width}) begin
        col_nxt = '0;
        row_nxt = row_inc[DIM_W-1:0];
        if (row_done) begin
          res.image_done = 1'b1;
          halted_nxt     = 1'b1;
        end
      end else begin
        col_nxt = pix_col_inc[DIM_W-1:0];
      end
    end

    if (do_span) begin
      res_valid       = 1'b1;
      res.kind        = KIND_SPAN;
      res.row         = eff_row;
      res.channel     = eff_plane;
      res.column      = eff_col;
      res.span_length = span_len;
      res.span_value  = b;
      if (span_sum >= {1'b0, img_width}) begin
        // plane full
        col_nxt = '0;
        lit_nxt = '0;
        if (eff_plane == PLANE_LAST) begin
          plane_nxt = '0;
          row_nxt   = row_inc[DIM_W-1:0];
          phase_nxt = PH_HEADER;
          if (row_done) begin
            res.image_done = 1'b1;
            halted_nxt     = 1'b1;
          end
        end else begin
          plane_nxt = eff_plane + 2'd1;
          phase_nxt = PH_COUNT;
        end
      end else begin
        col_nxt = span_sum[DIM_W-1:0];
        if ((eff_phase != PH_LITERAL) || (lit_nxt == 8'd0)) begin
          phase_nxt = PH_COUNT;
        end
      end
    end

    if (do_error) begin
      res_valid      = 1'b1;
      res.kind       = KIND_ERROR;
      res.error_code = err_code;
      res.row        = eff_row;
      res.channel    = eff_plane;
      res.column     = eff_col;
      res.image_done = 1'b1;
      halted_nxt     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      held_r   <= '0;
      pos_r    <= '0;
      flat_r   <= 1'b0;
      plane_r  <= '0;
      col_r    <= '0;
      row_r    <= '0;
      lit_r    <= '0;
      run_r    <= '0;
      halted_r <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      held_r   <= held_nxt;
      pos_r    <= pos_nxt;
      flat_r   <= flat_nxt;
      plane_r  <= plane_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      lit_r    <= lit_nxt;
      run_r    <= run_nxt;
      halted_r <= halted_nxt;
    end
  end

  `RGBERLE_ASSERT(a_halt_quiet, (halted_r && !in_start) |-> !res_valid, "result while halted")
  `RGBERLE_ASSERT(a_one_result, $countones({do_pixel, do_span, do_error}) <= 1, "two results")
  `RGBERLE_ASSERT_NEXT(a_done_halts, step && res_valid && res.image_done, halted_r, "done without halt")

endmodule

FILE: rtl/rgbe_rle_scanline_decoder.sv
// top level of the rgbe rle scanline decoder: channels, config registers, item stages
// depends on rgberle_pkg, rgberle_dec and rgbe_rle_scanline_decoder_macros.svh
//
// usage
//   in channel: one pixel-data byte of a radiance hdr file per item, with
//   start_image set on the first byte of an image (clears the decode state)
//   out channel: at most one result item per input byte: a channel span
//   (run or literal byte of one rle plane), a flat rgbe pixel, or an error;
//   image_done marks the last result of the image, after which bytes are
//   dropped until start_image
//   cfg channel: index 0 image width, index 1 image height; cfg_ready is
//   always high; write only while no item is in flight
// timing
//   an accepted byte sits one cycle in the input register and its result is
//   in the output register at the next edge: out_valid is high one cycle after
//   the accepting edge, so the result can be taken at the second edge after it
//   one byte per cycle sustained; the decode state is updated in that one
//   cycle so the next byte follows immediately
// reset and stall
//   synchronous active-low reset empties both stages, sets width 8, height 1
//   while out_stall holds a result, the input register still takes a byte;
//   a byte that yields no result moves on, one with a result waits
`include "rgbe_rle_scanline_decoder_macros.svh"

module rgbe_rle_scanline_decoder (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  rgberle_pkg::in_item_t    in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output rgberle_pkg::out_item_t   out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [14:0]              cfg_data
);
  import rgberle_pkg::*;

  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;

  // input register
  logic      in_valid_r;
  in_item_t  in_data_r;

  // output register
  logic      out_valid_r;
  out_item_t out_data_r;

  logic      res_valid;
  out_item_t res;
  logic      adv;
  logic      out_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_IDX_WIDTH) begin
        width_r <= cfg_data;
      end else begin
        height_r <= cfg_data;
      end
    end
  end

  // the held byte moves on unless its result finds the output register full and stalled
  assign adv      = in_valid_r && (!out_valid_r || !out_stall || !res_valid);
  assign out_load = adv && res_valid;
  assign in_stall = in_valid_r && !adv;

  rgberle_dec u_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (adv),
    .item       (in_data_r),
    .img_width  (width_r),
    .img_height (height_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RGBERLE_ASSERT(a_stall_needs_item, !in_valid_r |-> !in_stall, "stall with empty stage")
  `RGBERLE_ASSERT(a_error_done, (out_valid_r && (out_data_r.kind == KIND_ERROR)) |-> out_data_r.image_done, "error without done")
  `RGBERLE_ASSERT(a_span_len, (out_valid_r && (out_data_r.kind == KIND_SPAN)) |-> (out_data_r.span_length != 7'd0), "empty span")
  `RGBERLE_ASSERT_NEXT(a_out_drain, out_valid_r && !out_stall && !out_load, !out_valid_r, "result kept after take")

endmodule

FILE: dv/rgbe_rle_scanline_decoder_checker.sv
`timescale 1ns / 1ps
// checker for the rgbe rle scanline decoder: follows cfg writes, decodes every accepted
// byte on its own copy of the decode state and compares result items in order
// depends on rgberle_pkg
module rgbe_rle_scanline_decoder_checker (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  rgberle_pkg::in_item_t  in_data,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  rgberle_pkg::out_item_t out_data,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [14:0]            cfg_data,
  output int                     fail_count,
  output int                     pending
);
  import rgberle_pkg::*;

  localparam logic [7:0] RUN_FLAG = 8'h80;

  logic [DIM_W-1:0] img_width;
  logic [DIM_W-1:0] img_height;

  phase_t      ph;
  logic [23:0] held;
  logic [1:0]  byte_pos;
  logic        flat;
  logic [1:0]  plane;
  logic [15:0] col;
  logic [15:0] row;
  logic [7:0]  lit_left;
  logic [6:0]  run_len;
  logic        halted;

  // decoded item of the current byte, if any
  bit        has_result;
  out_item_t result;
  out_item_t want;
  out_item_t decoded_q[$];

  task automatic clear_decode();
    ph       = PH_HEADER;
    held     = '0;
    byte_pos = '0;
    flat     = 1'b0;
    plane    = '0;
    col      = '0;
    row      = '0;
    lit_left = '0;
    run_len  = '0;
    halted   = 1'b0;
  endtask

  task automatic make_error(input logic [1:0] code);
    has_result        = 1'b1;
    result.kind       = KIND_ERROR;
    result.error_code = code;
    result.row        = row[DIM_W-1:0];
    result.channel    = plane;
    result.column     = col[DIM_W-1:0];
    result.image_done = 1'b1;
    halted            = 1'b1;
  endtask

  task automatic make_pixel(input logic [23:0] rgb, input logic [7:0] e);
    has_result            = 1'b1;
    result.kind           = KIND_PIXEL;
    result.row            = row[DIM_W-1:0];
    result.column         = col[DIM_W-1:0];
    result.pixel_red      = rgb[7:0];
    result.pixel_green    = rgb[15:8];
    result.pixel_blue     = rgb[23:16];
    result.pixel_exponent = e;
    col = col + 16'd1;
    if (col >= img_width) begin
      col = '0;
      row = row + 16'd1;
      if (row >= img_height) begin
        result.image_done = 1'b1;
        halted            = 1'b1;
      end
    end
  endtask

  task automatic make_span(input logic [6:0] len, input logic [7:0] val);
    has_result         = 1'b1;
    result.kind        = KIND_SPAN;
    result.row         = row[DIM_W-1:0];
    result.channel     = plane;
    result.column      = col[DIM_W-1:0];
    result.span_length = len;
    result.span_value  = val;
    col = col + {9'd0, len};
    // a full plane moves on to the next one, the last plane ends the scanline
    if (col >= img_width) begin
      col      = '0;
      lit_left = '0;
      if (plane == PLANE_LAST) begin
        plane = '0;
        row   = row + 16'd1;
        ph    = PH_HEADER;
        if (row >= img_height) begin
          result.image_done = 1'b1;
          halted            = 1'b1;
        end
      end else begin
        plane = plane + 2'd1;
        ph    = PH_COUNT;
      end
    end else if (ph != PH_LITERAL || lit_left == 8'd0) begin
      ph = PH_COUNT;
    end
  endtask

  task automatic decode_byte(input in_item_t item);
    logic [7:0]  b;
    logic [23:0] rgb;
    logic [15:0] room;
    b          = item.file_byte;
    has_result = 1'b0;
    result     = '0;
    if (item.start_image)
      clear_decode();
    if (halted)
      return;
    if (img_width == '0 || img_height == '0 || row >= img_height)
      return;

    // flat pixels and scanline headers both gather four bytes
    if (flat || img_width < FLAT_LIMIT || ph == PH_HEADER) begin
      if (byte_pos < 2'd3) begin
        held     = held | ({16'd0, b} << (8 * byte_pos));
        byte_pos = byte_pos + 2'd1;
        return;
      end
      rgb      = held;
      held     = '0;
      byte_pos = '0;
      if (flat || img_width < FLAT_LIMIT) begin
        make_pixel(rgb, b);
        return;
      end
      // not an rle header: this and the rest of the image are flat pixels
      if (rgb[7:0] != HDR_MAGIC || rgb[15:8] != HDR_MAGIC || rgb[23]) begin
        flat = 1'b1;
        make_pixel(rgb, b);
        return;
      end
      if ({rgb[23:16], b} != {1'b0, img_width}) begin
        make_error(ERR_WIDTH);
        return;
      end
      ph    = PH_COUNT;
      plane = '0;
      col   = '0;
      return;
    end

    room = (col < img_width) ? {1'b0, img_width} - col : 16'd0;
    case (ph)
      PH_COUNT: begin
        if (b > RUN_FLAG) begin
          // count above 128: low seven bits are the run length
          run_len = b[6:0];
          if ({9'd0, run_len} > room)
            make_error(ERR_OVERRUN);
          else
            ph = PH_RUNVAL;
        end else if (b == 8'd0) begin
          make_error(ERR_ZERO);
        end else if ({8'd0, b} > room) begin
          make_error(ERR_OVERRUN);
        end else begin
          lit_left = b;
          ph       = PH_LITERAL;
        end
      end
      PH_RUNVAL: make_span(run_len, b);
      PH_LITERAL: begin
        if (lit_left > 8'd0)
          lit_left = lit_left - 8'd1;
        make_span(7'd1, b);
      end
      default: ph = PH_HEADER;
    endcase
  endtask

  function automatic void check_field(input string name, input logic [15:0] exp_val,
                                      input logic [15:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      img_width  = WIDTH_RESET;
      img_height = HEIGHT_RESET;
      clear_decode();
      decoded_q.delete();
      fail_count = 0;
      pending   <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_IDX_WIDTH)
          img_width = cfg_data;
        else
          img_height = cfg_data;
      end
      if (in_valid && !in_stall) begin
        decode_byte(in_data);
        if (has_result)
          decoded_q.push_back(result);
      end
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          $error("result item with none outstanding: kind %0d row %0d column %0d",
                 out_data.kind, out_data.row, out_data.column);
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          check_field("kind", 16'(want.kind), 16'(out_data.kind));
          check_field("error_code", 16'(want.error_code), 16'(out_data.error_code));
          check_field("row", 16'(want.row), 16'(out_data.row));
          check_field("channel", 16'(want.channel), 16'(out_data.channel));
          check_field("column", 16'(want.column), 16'(out_data.column));
          check_field("span_length", 16'(want.span_length), 16'(out_data.span_length));
          check_field("span_value", 16'(want.span_value), 16'(out_data.span_value));
          check_field("pixel_red", 16'(want.pixel_red), 16'(out_data.pixel_red));
          check_field("pixel_green", 16'(want.pixel_green), 16'(out_data.pixel_green));
          check_field("pixel_blue", 16'(want.pixel_blue), 16'(out_data.pixel_blue));
          check_field("pixel_exponent", 16'(want.pixel_exponent),
                      16'(out_data.pixel_exponent));
          check_field("image_done", 16'(want.image_done), 16'(out_data.image_done));
        end
      end
      pending <= decoded_q.size();
    end
  end

endmodule

FILE: dv/rgbe_rle_scanline_decoder_test.sv
`timescale 1ns / 1ps
// testbench top for the rgbe rle scanline decoder: clock, reset, register writes,
// directed and random byte streams, receiver stall patterns and the verdict
// depends on rgberle_pkg, the decoder rtl and rgbe_rle_scanline_decoder_checker
module rgbe_rle_scanline_decoder_test;
  import rgberle_pkg::*;

  localparam int          TOTAL_ITEMS  = 1850;
  localparam int          DRAIN_CYCLES = 4;          // input reg plus output reg, with margin
  localparam int          RUN_LIMIT_NS = 2_000_000;
  localparam logic [7:0]  RUN_FLAG     = 8'h80;
  localparam int          MAX_RUN      = 127;
  localparam int          MAX_LITERAL  = 128;
  localparam logic [14:0] DIM_MAX      = 15'h7fff;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURSTY} stall_mode_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_IDX_WIDTH;
  logic [14:0] cfg_data  = '0;

  int fail_count;
  int pending;

  // sender bookkeeping
  int   items_sent = 0;
  int   phase_end  = 0;
  int   burst_left = 0;
  logic start_next = 1'b0;

  // receiver stall pattern
  stall_mode_t stall_mode  = STALL_NONE;
  int          mode_left   = 0;
  int          hold_left   = 0;
  logic        stall_level = 1'b0;

  rgbe_rle_scanline_decoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rgbe_rle_scanline_decoder_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: pick a new stall style whenever the current one runs out
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(50, 300);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        // long on and off stretches
        if (hold_left == 0) begin
          stall_level = !stall_level;
          hold_left   = $urandom_range(1, 24);
        end
        hold_left--;
        out_stall <= stall_level;
      end
    endcase
  end

  // one item; bursts of random length, a random gap in front of each burst
  task automatic send_item(input logic [7:0] b, input logic s);
    int       gap;
    in_item_t item;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
      // gap of zero keeps valid high, so no lowering and raising in one step
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    item.file_byte   = b;
    item.start_image = s;
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // next byte of the stream, carrying start_image if an image was just begun
  task automatic put_byte(input logic [7:0] b);
    send_item(b, start_next);
    start_next = 1'b0;
  endtask

  // stray bytes with the odd start_image among them
  task automatic send_noise(input int count);
    repeat (count) send_item(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
  endtask

  // hold the sender until all predicted results are out and the pipe is empty
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // both registers back to back; valid stays high across the two writes
  task automatic set_dims(input logic [14:0] w, input logic [14:0] h);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_IDX_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one image of random content; mostly well formed, now and then a broken header
  // or a bad record count; stops early once the phase budget is used up
  task automatic send_image(input int w, input int h);
    int         r;
    int         p;
    int         c;
    int         n;
    int         room;
    int         wrong;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] hi;
    start_next = 1'b1;
    if (w < FLAT_LIMIT) begin
      // flat rgbe: four bytes per pixel
      for (r = 0; r < w * h && items_sent < phase_end; r++)
        repeat (4) put_byte(8'($urandom_range(0, 255)));
      return;
    end
    for (r = 0; r < h; r++) begin
      if (items_sent >= phase_end)
        return;
      case ($urandom_range(0, 39))
        0: begin
          // not an rle header: the decoder falls back to flat pixels
          b0 = 8'($urandom_range(0, 255));
          b1 = 8'($urandom_range(0, 255));
          hi = 8'($urandom_range(0, 255));
          if (b0 == HDR_MAGIC && b1 == HDR_MAGIC)
            hi = hi | 8'h80;
          put_byte(b0);
          put_byte(b1);
          put_byte(hi);
          put_byte(8'($urandom_range(0, 255)));
          repeat ($urandom_range(1, 6) * 4) put_byte(8'($urandom_range(0, 255)));
          return;
        end
        1: begin
          // header width that differs from the register
          wrong = (w ^ int'($urandom_range(1, DIM_MAX))) & int'(DIM_MAX);
          put_byte(HDR_MAGIC);
          put_byte(HDR_MAGIC);
          put_byte(wrong[15:8]);
          put_byte(wrong[7:0]);
          return;
        end
        default: begin
          put_byte(HDR_MAGIC);
          put_byte(HDR_MAGIC);
          put_byte(w[15:8]);
          put_byte(w[7:0]);
        end
      endcase
      for (p = 0; p < 4; p++) begin
        c = 0;
        while (c < w) begin
          if (items_sent >= phase_end)
            return;
          room = w - c;
          if ($urandom_range(0, 79) == 0) begin
            // zero count, or a run or literal longer than what is left of the plane
            if (room < MAX_RUN && $urandom_range(0, 1))
              put_byte(8'(RUN_FLAG + $urandom_range(room + 1, MAX_RUN)));
            else if (room < MAX_LITERAL && $urandom_range(0, 1))
              put_byte(8'($urandom_range(room + 1, MAX_LITERAL)));
            else
              put_byte(8'h00);
            return;
          end
          if ($urandom_range(0, 1)) begin
            n = (room < MAX_RUN) ? room : MAX_RUN;
            if ($urandom_range(0, 2) != 0)
              n = $urandom_range(1, n);
            put_byte(8'(RUN_FLAG + n));
            put_byte(8'($urandom_range(0, 255)));
          end else begin
            n = (room < MAX_LITERAL) ? room : MAX_LITERAL;
            if ($urandom_range(0, 2) != 0)
              n = $urandom_range(1, n);
            put_byte(8'(n));
            repeat (n) put_byte(8'($urandom_range(0, 255)));
          end
          c += n;
        end
      end
    end
  endtask

  initial begin
    int phase_no;
    int w;
    int h;
    phase_no = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part on the reset registers: width 8, height 1
    // literal of one, run of seven, then a literal count past the end of the plane
    start_next = 1'b1;
    put_byte(HDR_MAGIC); put_byte(HDR_MAGIC); put_byte(8'h00); put_byte(8'h08);
    put_byte(8'h01); put_byte(8'hAA); put_byte(8'h87); put_byte(8'h55);
    put_byte(8'h80);
    // header with the largest width, which does not match
    start_next = 1'b1;
    put_byte(HDR_MAGIC); put_byte(HDR_MAGIC); put_byte(8'h7F); put_byte(8'hFF);
    // zero count right after a good header
    start_next = 1'b1;
    put_byte(HDR_MAGIC); put_byte(HDR_MAGIC); put_byte(8'h00); put_byte(8'h08);
    put_byte(8'h00);
    // hi byte with bit 7 set: header read as a flat pixel, then one more pixel
    start_next = 1'b1;
    put_byte(HDR_MAGIC); put_byte(HDR_MAGIC); put_byte(8'h80); put_byte(8'h07);
    put_byte(8'h00); put_byte(8'hFF); put_byte(8'h00); put_byte(8'hFF);
    wait_for_drain();

    // random phases, each with its own image size
    while (items_sent < TOTAL_ITEMS) begin
      case (phase_no % 8)
        0: begin w = 1; h = 1; end
        1: begin w = 7; h = $urandom_range(1, 4); end
        2: begin
          w = 8;
          h = ($urandom_range(0, 3) == 0) ? int'(DIM_MAX) : $urandom_range(1, 3);
        end
        3: begin w = $urandom_range(9, 24); h = $urandom_range(1, 3); end
        4: begin w = $urandom_range(2, 6); h = int'(DIM_MAX); end
        5: begin w = int'(DIM_MAX); h = $urandom_range(1, 2); end
        6: begin w = $urandom_range(128, 300); h = $urandom_range(1, 2); end
        default: begin w = $urandom_range(8, 16); h = $urandom_range(1, 2); end
      endcase
      set_dims(15'(w), 15'(h));
      phase_end = items_sent + $urandom_range(100, 220);
      // sometimes carry on from the unfinished image under the new sizes
      if ($urandom_range(0, 3) == 0)
        send_noise(20);
      while (items_sent < phase_end)
        send_image(w, h);
      wait_for_drain();
      phase_no++;
    end

    repeat (DRAIN_CYCLES * 4) @(posedge clk);
    if (fail_count == 0)
      $display("PASS rgbe_rle_scanline_decoder");
    else
      $display("FAIL rgbe_rle_scanline_decoder");
    $finish;
  end

  // run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("FAIL rgbe_rle_scanline_decoder");
    $finish;
  end

endmodule
